// ----- hw/rtl/ief_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ief_pkg
// Shared types and constants of the I2C target EEPROM fault injector.
// ---------------------------------------------------------------------------
package ief_pkg;

    localparam int STORE_BYTES      = 256;
    localparam int STORE_AW         = $clog2(STORE_BYTES);
    localparam int EEPROM_BYTES_DEF = 128;

    localparam logic [7:0]  FILL_BYTE = 8'h55;
    localparam logic [7:0]  DISARMED  = 8'hFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // control register map
    localparam logic [7:0] RG_RESERVED = 8'hF8;
    localparam logic [7:0] RG_HOLD_HI  = 8'hF9;
    localparam logic [7:0] RG_HOLD_LO  = 8'hFA;
    localparam logic [7:0] RG_HOLD_RD  = 8'hFB;
    localparam logic [7:0] RG_HOLD_WR  = 8'hFC;
    localparam logic [7:0] RG_NAK      = 8'hFD;
    localparam logic [7:0] RG_CRC_UPD  = 8'hFE;
    localparam logic [7:0] RG_CRC_RST  = 8'hFF;

    localparam logic [7:0] HOLD_HI_DEF = 8'h3A;
    localparam logic [7:0] HOLD_LO_DEF = 8'h98;

    typedef enum logic [2:0] {
        K_ADDR_WR  = 3'd0,
        K_BYTE     = 3'd1,
        K_RD_START = 3'd2,
        K_RD_NEXT  = 3'd3,
        K_STOP     = 3'd4,
        K_BUS_ERR  = 3'd5,
        K_NOP      = 3'd6
    } t_kind;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } t_mem_wr;

    typedef struct packed {
        logic        ack;
        logic [7:0]  read_data;
        logic        hold;
        logic [15:0] hold_ms;
        logic        bus_err;
    } t_result;

endpackage
`default_nettype wire

// ----- hw/rtl/ief_mem.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ief_mem
// Byte store, one write and one registered read port. Swept to the fill
// pattern after reset, one entry a cycle.
// ---------------------------------------------------------------------------
module ief_mem (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ief_pkg::t_mem_wr             i_wr,
    input  wire logic                         i_rd_en,
    input  wire logic [ief_pkg::STORE_AW-1:0] i_rd_addr,
    output logic      [7:0]                   o_rd_data,
    output logic                              o_clearing
);

    logic [7:0]                   r_mem [ief_pkg::STORE_BYTES];
    logic [7:0]                   r_rd_data;
    logic                         r_clearing;
    logic [ief_pkg::STORE_AW-1:0] r_clr_addr;

    logic                         wr_en;
    logic [ief_pkg::STORE_AW-1:0] wr_addr;
    logic [7:0]                   wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ief_pkg::STORE_AW'(ief_pkg::STORE_BYTES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = ief_pkg::FILL_BYTE;
        end else begin
            wr_en   = i_wr.we;
            wr_addr = i_wr.addr;
            wr_data = i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule
`default_nettype wire

// ----- hw/rtl/ief_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ief_core
// Event execution: control registers, fault countdowns, CRC and address
// pointer. Works on the store byte read in the previous cycle.
// ---------------------------------------------------------------------------
module ief_core #(
    parameter int EEPROM_BYTES = ief_pkg::EEPROM_BYTES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_exec,
    input  wire ief_pkg::t_kind               i_kind,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic [7:0]                   i_mem_rd_data,
    output logic      [ief_pkg::STORE_AW-1:0] o_cur_addr,
    output ief_pkg::t_mem_wr                  o_wr,
    output ief_pkg::t_result                  o_res
);

    localparam logic [7:0] EeEnd  = 8'(EEPROM_BYTES);
    localparam logic [7:0] EeLast = 8'(EEPROM_BYTES - 1);

    logic [7:0]  r_cur_addr, n_cur_addr;
    logic [7:0]  r_down, n_down;
    logic        r_expect, n_expect;
    logic        r_nak_mode, n_nak_mode;
    logic        r_holdw_mode, n_holdw_mode;
    logic        r_holdr_mode, n_holdr_mode;
    logic        r_err, n_err;
    logic [7:0]  r_hold_hi, n_hold_hi;
    logic [7:0]  r_hold_lo, n_hold_lo;
    logic [7:0]  r_hold_rd, n_hold_rd;
    logic [7:0]  r_hold_wr, n_hold_wr;
    logic [7:0]  r_nak, n_nak;
    logic [15:0] r_crc, n_crc;

    logic [7:0]  dec;
    logic [7:0]  step_addr;
    logic [7:0]  rd_val;

    function automatic logic [15:0] f_crc_feed(input logic [15:0] c_in, input logic [7:0] d);
        logic [15:0] c;
        c = c_in ^ {d, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ ief_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // pointer wraps inside the EEPROM, elsewhere it just counts
    assign dec       = r_down - 8'd1;
    assign step_addr = (r_cur_addr < EeEnd) ? ((r_cur_addr == EeLast) ? 8'd0 : r_cur_addr + 8'd1)
                                            : r_cur_addr + 8'd1;

    always_comb begin
        unique case (r_cur_addr)
            ief_pkg::RG_RESERVED: rd_val = 8'h00;
            ief_pkg::RG_HOLD_HI:  rd_val = r_hold_hi;
            ief_pkg::RG_HOLD_LO:  rd_val = r_hold_lo;
            ief_pkg::RG_HOLD_RD:  rd_val = r_hold_rd;
            ief_pkg::RG_HOLD_WR:  rd_val = r_hold_wr;
            ief_pkg::RG_NAK:      rd_val = r_nak;
            ief_pkg::RG_CRC_UPD:  rd_val = r_crc[15:8];
            ief_pkg::RG_CRC_RST:  rd_val = r_crc[7:0];
            default:              rd_val = i_mem_rd_data;
        endcase
    end

    always_comb begin
        n_cur_addr   = r_cur_addr;
        n_down       = r_down;
        n_expect     = r_expect;
        n_nak_mode   = r_nak_mode;
        n_holdw_mode = r_holdw_mode;
        n_holdr_mode = r_holdr_mode;
        n_err        = r_err;
        n_hold_hi    = r_hold_hi;
        n_hold_lo    = r_hold_lo;
        n_hold_rd    = r_hold_rd;
        n_hold_wr    = r_hold_wr;
        n_nak        = r_nak;
        n_crc        = r_crc;
        o_wr         = '0;
        o_res        = '0;

        unique case (i_kind)
            ief_pkg::K_ADDR_WR: begin
                n_expect = 1'b1;
                if (r_nak != ief_pkg::DISARMED) begin
                    if (r_nak != 8'd0) begin
                        o_res.ack    = 1'b1;
                        n_down       = r_nak;
                        n_nak_mode   = 1'b1;
                        n_holdw_mode = 1'b0;
                    end
                    n_nak = ief_pkg::DISARMED;
                end else if (r_hold_wr != ief_pkg::DISARMED) begin
                    if (r_hold_wr == 8'd0) begin
                        o_res.hold = 1'b1;
                    end else begin
                        n_down       = r_hold_wr;
                        n_holdw_mode = 1'b1;
                        n_nak_mode   = 1'b0;
                    end
                    o_res.ack = 1'b1;
                    n_hold_wr = ief_pkg::DISARMED;
                end else begin
                    o_res.ack    = 1'b1;
                    n_nak_mode   = 1'b0;
                    n_holdw_mode = 1'b0;
                end
            end
            ief_pkg::K_BYTE: begin
                if (r_nak_mode) begin
                    n_down = dec;
                    if (dec == 8'd0) begin
                        n_nak_mode = 1'b0;
                    end else begin
                        o_res.ack = 1'b1;
                    end
                end else if (r_holdw_mode) begin
                    n_down    = dec;
                    o_res.ack = 1'b1;
                    if (dec == 8'd0) begin
                        o_res.hold   = 1'b1;
                        n_holdw_mode = 1'b0;
                    end
                end else begin
                    o_res.ack = 1'b1;
                    if (r_expect) begin
                        n_cur_addr = i_data_byte;
                        n_expect   = 1'b0;
                    end else if (r_cur_addr < EeEnd) begin
                        // the kind stays registered after execution, so only
                        // the execute cycle may write the store
                        o_wr.we    = i_exec;
                        o_wr.addr  = r_cur_addr;
                        o_wr.data  = i_data_byte;
                        n_cur_addr = step_addr;
                    end else begin
                        unique case (r_cur_addr)
                            ief_pkg::RG_HOLD_HI: begin
                                n_hold_hi  = i_data_byte;
                                n_cur_addr = ief_pkg::RG_HOLD_LO;
                            end
                            ief_pkg::RG_HOLD_LO: n_hold_lo = i_data_byte;
                            ief_pkg::RG_HOLD_RD: n_hold_rd = i_data_byte;
                            ief_pkg::RG_HOLD_WR: n_hold_wr = i_data_byte;
                            ief_pkg::RG_NAK:     n_nak     = i_data_byte;
                            ief_pkg::RG_CRC_UPD: n_crc     = f_crc_feed(r_crc, i_data_byte);
                            ief_pkg::RG_CRC_RST: n_crc     = 16'h0000;
                            default: ;
                        endcase
                    end
                end
            end
            ief_pkg::K_RD_START, ief_pkg::K_RD_NEXT: begin
                o_res.ack = 1'b1;
                if (i_kind == ief_pkg::K_RD_START && r_hold_rd != ief_pkg::DISARMED) begin
                    if (r_hold_rd == 8'd0) begin
                        n_down       = 8'd0;
                        o_res.hold   = 1'b1;
                        n_holdr_mode = 1'b0;
                    end else begin
                        n_down       = r_hold_rd;
                        n_holdr_mode = 1'b1;
                    end
                    o_res.read_data = r_hold_rd;
                    n_hold_rd       = ief_pkg::DISARMED;
                end else if (r_holdr_mode) begin
                    n_down          = dec;
                    o_res.read_data = dec;
                    if (dec == 8'd0) begin
                        o_res.hold   = 1'b1;
                        n_holdr_mode = 1'b0;
                    end
                end else begin
                    o_res.read_data = rd_val;
                    n_cur_addr      = step_addr;
                end
            end
            ief_pkg::K_BUS_ERR: n_err = 1'b1;
            default: ;
        endcase

        o_res.hold_ms = o_res.hold ? {r_hold_hi, r_hold_lo} : 16'h0000;
        o_res.bus_err = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_addr   <= '0;
            r_down       <= '0;
            r_expect     <= 1'b0;
            r_nak_mode   <= 1'b0;
            r_holdw_mode <= 1'b0;
            r_holdr_mode <= 1'b0;
            r_err        <= 1'b0;
            r_hold_hi    <= ief_pkg::HOLD_HI_DEF;
            r_hold_lo    <= ief_pkg::HOLD_LO_DEF;
            r_hold_rd    <= ief_pkg::DISARMED;
            r_hold_wr    <= ief_pkg::DISARMED;
            r_nak        <= ief_pkg::DISARMED;
            r_crc        <= '0;
        end else if (i_exec) begin
            r_cur_addr   <= n_cur_addr;
            r_down       <= n_down;
            r_expect     <= n_expect;
            r_nak_mode   <= n_nak_mode;
            r_holdw_mode <= n_holdw_mode;
            r_holdr_mode <= n_holdr_mode;
            r_err        <= n_err;
            r_hold_hi    <= n_hold_hi;
            r_hold_lo    <= n_hold_lo;
            r_hold_rd    <= n_hold_rd;
            r_hold_wr    <= n_hold_wr;
            r_nak        <= n_nak;
            r_crc        <= n_crc;
        end
    end

    assign o_cur_addr = r_cur_addr;

endmodule
`default_nettype wire

// ----- hw/rtl/i2c_target_eeprom_fault_injector.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// i2c_target_eeprom_fault_injector
// I2C target test device: EEPROM emulation with NAK, clock-stretch and CRC
// fault registers, driven by decoded bus events.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The store byte at
// the current address is read when the request is taken; in the EXEC state
// the event is executed and the store written back; the result then sits on
// the o_ ports, marked by o_valid for one cycle, and cannot be held off.
// Busy is high during execution, so a new request is taken only once the
// previous one has executed, at the earliest in its result cycle; the store
// read is registered ahead of execution. After reset the 256-byte store is
// swept to its fill pattern, one byte a cycle; busy is high throughout.
module i2c_target_eeprom_fault_injector #(
    parameter int EEPROM_BYTES = ief_pkg::EEPROM_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_kind,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    output logic             o_ack,
    output logic [7:0]       o_read_data,
    output logic             o_hold_request,
    output logic [15:0]      o_hold_ms,
    output logic             o_bus_error_seen
);

    ief_pkg::t_state r_state, n_state;
    logic [2:0]      r_kind;
    logic [7:0]      r_data_byte;
    logic            r_valid;
    ief_pkg::t_result r_res;

    logic                         accept;
    logic                         exec;
    logic                         clearing;
    logic [7:0]                   mem_rd_data;
    logic [ief_pkg::STORE_AW-1:0] cur_addr;
    ief_pkg::t_mem_wr             wr;
    ief_pkg::t_result             res;

    assign busy   = (r_state != ief_pkg::S_IDLE) || clearing;
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        exec    = 1'b0;
        unique case (r_state)
            ief_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = ief_pkg::S_EXEC;
                end
            end
            ief_pkg::S_EXEC: begin
                exec    = 1'b1;
                n_state = ief_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ief_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind      <= i_kind;
            r_data_byte <= i_data_byte;
        end
        if (exec) begin
            r_res <= res;
        end
    end

    ief_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_rd_en    (accept),
        .i_rd_addr  (cur_addr),
        .o_rd_data  (mem_rd_data),
        .o_clearing (clearing)
    );

    ief_core #(
        .EEPROM_BYTES (EEPROM_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_exec        (exec),
        .i_kind        (ief_pkg::t_kind'(r_kind)),
        .i_data_byte   (r_data_byte),
        .i_mem_rd_data (mem_rd_data),
        .o_cur_addr    (cur_addr),
        .o_wr          (wr),
        .o_res         (res)
    );

    assign o_valid          = r_valid;
    assign o_ack            = r_res.ack;
    assign o_read_data      = r_res.read_data;
    assign o_hold_request   = r_res.hold;
    assign o_hold_ms        = r_res.hold_ms;
    assign o_bus_error_seen = r_res.bus_err;

    // each executed request gives exactly one result, in the following cycle
    a_valid_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ief_pkg::S_EXEC) |=> o_valid)
        else $error("result strobe missing after execution");

    a_valid_only_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ief_pkg::S_EXEC))
        else $error("result strobe without an executed request");

    // no store write from the core while the sweep still owns the port
    a_no_write_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.we |-> (!clearing && exec))
        else $error("store write outside execution");

    a_hold_ms_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hold_request) |-> (o_hold_ms == 16'h0000))
        else $error("hold time shown without a stretch request");

endmodule
`default_nettype wire
